// ===== rtl/rli_pkg.sv =====
package rli_pkg;

  localparam int unsigned TableDepth = 4096;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned ValW       = 20;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned CntW       = 13;
  localparam int unsigned NumCh      = 3;

  // value * last, value * 2^FracBits-scaled span, interpolation widths
  localparam int unsigned ScaledW = ValW + AddrW + 1;
  localparam int unsigned SpanW   = AddrW + FracBits;
  localparam int unsigned DiffW   = ValW + 1;
  localparam int unsigned ProdW   = DiffW + FracBits + 1;
  localparam int unsigned SumW    = ProdW - FracBits;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  typedef logic signed [ValW-1:0] value_t;

  typedef struct packed {
    logic [AddrW-1:0] lo;
    logic [AddrW-1:0] hi;
  } rd_addr_t;

endpackage

// ===== rtl/rgb_lut1d_linear_interp_core.sv =====
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid_i/tready_o       tdata: table + pixel, tuser: cmd, tlast
// m_axis    out  m_axis_tvalid_o/tready_i       tdata: interpolated pixel, tlast
// cfg       in   cfg_valid_i/cfg_ready_o        cfg_data_i: entries_in_use
//
// One transfer per clock while the output is not held by m_axis_tready_i.
// Pipeline: multiply, clamp + table read, interpolation multiply, add + output reg.
// Table writes land in the RAMs at the read stage, in order with pixels: no hazard.
// Stalls only collapse bubbles; a full pipeline holds while m_axis_tready_i is low.
// Reset clears control and the entry count (4096); table contents are undefined.
module rgb_lut1d_linear_interp_core
  import rli_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid_i,
  output logic          s_axis_tready_o,
  // [1:0] table_channel, [13:2] table_index, [33:14] table_value, [53:34] red_in,
  // [73:54] green_in, [93:74] blue_in, [113:94] alpha_in, [119:114] zero
  input  logic [119:0]  s_axis_tdata_i,
  // [0] cmd
  input  logic          s_axis_tuser_i,
  input  logic          s_axis_tlast_i,
  output logic          m_axis_tvalid_o,
  input  logic          m_axis_tready_i,
  // [19:0] red_out, [39:20] green_out, [59:40] blue_out, [79:60] alpha_out
  output logic [79:0]   m_axis_tdata_o,
  output logic          m_axis_tlast_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [CntW-1:0] cfg_data_i
);

  // entry count held as last index in use
  logic [AddrW-1:0] last_q;
  logic [AddrW-1:0] last_d;

  always_comb begin
    if (cfg_data_i < CntW'(2)) begin
      last_d = AddrW'(1);
    end else if (cfg_data_i > CntW'(TableDepth)) begin
      last_d = AddrW'(TableDepth - 1);
    end else begin
      last_d = AddrW'(cfg_data_i - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= AddrW'(TableDepth - 1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      last_q <= last_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  // stage enables: a stage moves when it is empty or the next one moves
  logic v1_q, v2_q, v3_q, vo_q;
  logic en1, en2, en3, en_o;

  assign en_o = !vo_q || m_axis_tready_i;
  assign en3  = !v3_q || en_o;
  assign en2  = !v2_q || en3;
  assign en1  = !v1_q || en2;
  assign s_axis_tready_o = en1;

  // input fields
  value_t in_val [NumCh];
  assign in_val[0] = s_axis_tdata_i[53:34];
  assign in_val[1] = s_axis_tdata_i[73:54];
  assign in_val[2] = s_axis_tdata_i[93:74];

  // stage 1 side fields
  logic             cmd1_q;
  logic [1:0]       ch1_q;
  logic [AddrW-1:0] idx1_q;
  value_t           tval1_q;
  value_t           alpha1_q, alpha2_q, alpha3_q;
  logic             last1_q, last2_q, last3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid_i;
      // write items leave the pipe once the RAM has them
      if (en2) v2_q <= v1_q && (cmd1_q == CMD_PIXEL);
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      cmd1_q   <= s_axis_tuser_i;
      ch1_q    <= s_axis_tdata_i[1:0];
      idx1_q   <= s_axis_tdata_i[13:2];
      tval1_q  <= s_axis_tdata_i[33:14];
      alpha1_q <= s_axis_tdata_i[113:94];
      last1_q  <= s_axis_tlast_i;
    end
    if (en2) begin
      alpha2_q <= alpha1_q;
      last2_q  <= last1_q;
    end
    if (en3) begin
      alpha3_q <= alpha2_q;
      last3_q  <= last2_q;
    end
  end

  // per-channel datapath
  rd_addr_t            addr  [NumCh];
  logic [FracBits-1:0] frac  [NumCh];
  value_t              p_dat [NumCh];
  value_t              q_dat [NumCh];
  value_t              res   [NumCh];
  logic [1:0]          ch_code [NumCh];

  assign ch_code[0] = CH_RED;
  assign ch_code[1] = CH_GREEN;
  assign ch_code[2] = CH_BLUE;

  for (genvar c = 0; c < NumCh; c++) begin : g_ch
    rli_scale u_scale (
      .clk_i     (clk_i),
      .en_mul_i  (en1),
      .en_frac_i (en2),
      .value_i   (in_val[c]),
      .last_i    (last_q),
      .addr_o    (addr[c]),
      .frac_o    (frac[c])
    );

    rli_table_ram u_ram (
      .clk_i     (clk_i),
      .we_i      (en2 && v1_q && (cmd1_q == CMD_WRITE) && (ch1_q == ch_code[c])),
      .waddr_i   (idx1_q),
      .wdata_i   (tval1_q),
      .re_i      (en2),
      .raddr_i   (addr[c]),
      .lo_data_o (p_dat[c]),
      .hi_data_o (q_dat[c])
    );

    rli_interp u_interp (
      .clk_i    (clk_i),
      .en_i     (en3),
      .lo_i     (p_dat[c]),
      .hi_i     (q_dat[c]),
      .frac_i   (frac[c]),
      .result_o (res[c])
    );
  end

  // output register
  logic [79:0] tdata_q;
  logic        tlast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_o) begin
      vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      tdata_q <= {alpha3_q, res[2], res[1], res[0]};
      tlast_q <= last3_q;
    end
  end

  assign m_axis_tvalid_o = vo_q;
  assign m_axis_tdata_o  = tdata_q;
  assign m_axis_tlast_o  = tlast_q;

  // ---------------------------------------------------------------------------
  // Assertions
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vo_q |-> s_axis_tready_o)
    else $error("input stalled with empty output register");

  a_last_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_q != '0)
    else $error("entry count below two");

  a_lo_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && cmd1_q == CMD_PIXEL) |-> (addr[0].lo <= last_q && addr[0].hi <= last_q))
    else $error("red table index beyond last entry");

  a_hi_follows_lo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && cmd1_q == CMD_PIXEL) |->
      (addr[1].hi == addr[1].lo || addr[1].hi == addr[1].lo + 1'b1))
    else $error("green upper index not next to lower index");

endmodule

// ===== rtl/rli_table_ram.sv =====
module rli_table_ram
  import rli_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  value_t           wdata_i,
  input  logic             re_i,
  input  rd_addr_t         raddr_i,
  output value_t           lo_data_o,
  output value_t           hi_data_o
);

  value_t mem_q [TableDepth];
  value_t lo_q;
  value_t hi_q;

  // one write port, two read ports, registered read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      lo_q <= mem_q[raddr_i.lo];
      hi_q <= mem_q[raddr_i.hi];
    end
  end

  assign lo_data_o = lo_q;
  assign hi_data_o = hi_q;

endmodule

// ===== rtl/rli_scale.sv =====
module rli_scale
  import rli_pkg::*;
(
  input  logic                clk_i,
  input  logic                en_mul_i,
  input  logic                en_frac_i,
  input  value_t              value_i,
  input  logic [AddrW-1:0]    last_i,
  output rd_addr_t            addr_o,
  output logic [FracBits-1:0] frac_o
);

  logic signed [ScaledW-1:0] scaled_q;
  logic [SpanW-1:0]          span_max;
  logic [SpanW-1:0]          span;
  logic [AddrW-1:0]          lo;
  logic [FracBits-1:0]       frac_q;

  always_ff @(posedge clk_i) begin
    if (en_mul_i) begin
      scaled_q <= ScaledW'(value_i * $signed({1'b0, last_i}));
    end
  end

  assign span_max = {last_i, {FracBits{1'b0}}};

  // clamp to [0, last]
  always_comb begin
    if (scaled_q[ScaledW-1]) begin
      span = '0;
    end else if (scaled_q > $signed({{(ScaledW-SpanW){1'b0}}, span_max})) begin
      span = span_max;
    end else begin
      span = scaled_q[SpanW-1:0];
    end
  end

  assign lo        = span[SpanW-1:FracBits];
  assign addr_o.lo = lo;
  assign addr_o.hi = (lo == last_i) ? lo : lo + 1'b1;

  // fraction lines up with the table read data
  always_ff @(posedge clk_i) begin
    if (en_frac_i) begin
      frac_q <= span[FracBits-1:0];
    end
  end

  assign frac_o = frac_q;

endmodule

// ===== rtl/rli_interp.sv =====
module rli_interp
  import rli_pkg::*;
(
  input  logic                clk_i,
  input  logic                en_i,
  input  value_t              lo_i,
  input  value_t              hi_i,
  input  logic [FracBits-1:0] frac_i,
  output value_t              result_o
);

  logic signed [DiffW-1:0] diff;
  logic signed [ProdW-1:0] prod_q;
  value_t                  lo_q;
  logic signed [SumW-1:0]  sum;

  assign diff = DiffW'(hi_i) - DiffW'(lo_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= ProdW'(diff * $signed({1'b0, frac_i}));
      lo_q   <= lo_i;
    end
  end

  // arithmetic shift gives the floor
  assign sum      = SumW'(lo_q) + SumW'(prod_q >>> FracBits);
  assign result_o = sum[ValW-1:0];

endmodule

// ===== verif/tb_rgb_lut1d_linear_interp_core.sv =====
`timescale 1ns / 100ps

// Testbench for the per-channel 1D LUT core with linear interpolation.
// A scoreboard class mirrors the three tables and the entry count, predicts one
// output pixel per pixel command and checks every m_axis transfer in order.
// Table writes are tracked so that a pixel never reads an entry that was
// never loaded (RAM contents are undefined until written).
module tb_rgb_lut1d_linear_interp_core;
  import rli_pkg::*;

  localparam int          ClkHalf       = 10;    // 20 ns period
  localparam int          ResetCycles   = 8;
  localparam int          DrainCycles   = 8;
  localparam int          RxHoldCycles  = 80;    // long sink stall, fills the pipe
  localparam int          WatchdogLimit = 5000;  // cycles without any transfer
  localparam int          PhaseItems    = 160;
  localparam int          NumPhases     = 9;
  localparam logic [1:0]  CH_NONE       = 2'd3;  // write to it is dropped

  // entries_in_use per phase: minimum, saturating values, odd sizes, full depth
  localparam logic [CntW-1:0] PhaseCounts [NumPhases] =
    '{13'd2, 13'd8191, 13'd0, 13'd37, 13'd4096, 13'd1, 13'd600, 13'd4097, 13'd3};

  typedef struct {
    value_t red;
    value_t green;
    value_t blue;
    value_t alpha;
    logic   frame_end;
  } pixel_out_t;

  // Mirror of the tables and the entry count; queue of pixels still owed.
  class lut_pixel_scoreboard;
    value_t     lut [NumCh][TableDepth];
    bit         loaded [NumCh][TableDepth];
    int         loaded_idx [NumCh][$];
    int         entry_count = TableDepth;
    pixel_out_t pending_pixels [$];
    int         errors = 0;

    function void set_entry_count(logic [CntW-1:0] raw);
      if (raw < 2) begin
        entry_count = 2;
      end else if (raw > TableDepth) begin
        entry_count = TableDepth;
      end else begin
        entry_count = int'(raw);
      end
    endfunction

    // scale, clamp, split into index + fraction, floor-interpolate
    function value_t interp_entry(int ch, value_t v);
      longint span, scaled, top, frac, p, q;
      int     lo, hi;
      span   = entry_count - 1;
      scaled = longint'(v) * span;
      top    = span <<< FracBits;
      if (scaled < 0) scaled = 0;
      if (scaled > top) scaled = top;
      lo   = int'(scaled >>> FracBits);
      frac = scaled & ((longint'(1) <<< FracBits) - 1);
      hi   = (lo + 1 > span) ? int'(span) : lo + 1;
      p    = lut[ch][lo];
      q    = lut[ch][hi];
      return value_t'(p + (((q - p) * frac) >>> FracBits));
    endfunction

    function void note_input(logic cmd, logic [1:0] ch, logic [AddrW-1:0] idx, value_t val,
                             value_t r, value_t g, value_t b, value_t a, logic fe);
      pixel_out_t px;
      if (cmd == CMD_WRITE) begin
        if (ch <= CH_BLUE) begin
          lut[ch][idx] = val;
          if (!loaded[ch][idx]) begin
            loaded[ch][idx] = 1'b1;
            loaded_idx[ch].push_back(int'(idx));
          end
        end
      end else begin
        px.red       = interp_entry(CH_RED, r);
        px.green     = interp_entry(CH_GREEN, g);
        px.blue      = interp_entry(CH_BLUE, b);
        px.alpha     = a;
        px.frame_end = fe;
        pending_pixels.push_back(px);
      end
    endfunction

    function void compare_field(string field, logic [ValW-1:0] want, logic [ValW-1:0] got);
      if (got !== want) begin
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(pixel_out_t got);
      pixel_out_t want;
      if (pending_pixels.size() == 0) begin
        $display("%0t ns: unexpected pixel, expected none, got %h %h %h %h last %b",
                 $time, got.red, got.green, got.blue, got.alpha, got.frame_end);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      compare_field("red", want.red, got.red);
      compare_field("green", want.green, got.green);
      compare_field("blue", want.blue, got.blue);
      compare_field("alpha", want.alpha, got.alpha);
      compare_field("frame_end", ValW'(want.frame_end), ValW'(got.frame_end));
    endfunction
  endclass

  logic            clk_i = 1'b0;
  logic            rst_ni;
  logic            s_axis_tvalid_i;
  logic            s_axis_tready_o;
  logic [119:0]    s_axis_tdata_i;   // channel, index, value, red, green, blue, alpha, pad
  logic            s_axis_tuser_i;   // cmd
  logic            s_axis_tlast_i;
  logic            m_axis_tvalid_o;
  logic            m_axis_tready_i;
  logic [79:0]     m_axis_tdata_o;   // red, green, blue, alpha
  logic            m_axis_tlast_o;
  logic            cfg_valid_i;
  logic            cfg_ready_o;
  logic [CntW-1:0] cfg_data_i;

  lut_pixel_scoreboard sb = new();

  int unsigned tx_idle_pct;   // chance in 100 that the source skips a cycle
  int unsigned rx_idle_pct;   // chance in 100 that the sink drops tready
  bit          rx_hold_req;   // asks the sink process for one long stall
  int          quiet_cycles;

  rgb_lut1d_linear_interp_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  function automatic value_t rand_value();
    return value_t'($urandom());
  endfunction

  // One s_axis transfer. Random gaps first; tvalid stays high between
  // back-to-back items so it is never dropped and raised in the same step.
  task automatic send_item(logic cmd, logic [1:0] ch, logic [AddrW-1:0] idx, value_t val,
                           value_t r, value_t g, value_t b, value_t a, logic fe);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {6'd0, a, b, g, r, val, idx, ch};
    s_axis_tuser_i  <= cmd;
    s_axis_tlast_i  <= fe;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_input(cmd, ch, idx, val, r, g, b, a, fe);
  endtask

  // Table write: pixel fields carry junk, the core must ignore them.
  task automatic write_lut(logic [1:0] ch, logic [AddrW-1:0] idx, value_t val);
    send_item(CMD_WRITE, ch, idx, val, rand_value(), rand_value(), rand_value(),
              rand_value(), 1'($urandom()));
  endtask

  // Pixel: table fields carry junk.
  task automatic send_pixel(value_t r, value_t g, value_t b, value_t a, logic fe);
    send_item(CMD_PIXEL, 2'($urandom()), AddrW'($urandom()), rand_value(), r, g, b, a, fe);
  endtask

  // Source goes quiet until every pixel is back, then lets in-flight writes
  // (which return nothing) clear the pipeline.
  task automatic drain_pipeline();
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_entry_count(logic [CntW-1:0] raw);
    drain_pipeline();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= raw;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_entry_count(raw);
  endtask

  // Channel input whose lookup only touches loaded entries. Mix of clamped
  // negatives, clamped large values, exact ends and interior points.
  function automatic value_t pick_channel_in(int c);
    int span, mode, k, hi, lo_v, hi_v;
    span = sb.entry_count - 1;
    mode = $urandom_range(15);
    if (mode < 2) return value_t'(-int'($urandom_range(524288, 1)));
    if (mode == 2) return value_t'($urandom_range(524287, 65537));
    if (mode == 3) return $urandom_range(1) ? value_t'(0) : value_t'(1 << FracBits);
    repeat (16) begin
      k  = sb.loaded_idx[c][$urandom_range(sb.loaded_idx[c].size() - 1)];
      hi = (k < span) ? k + 1 : span;
      if (k <= span && sb.loaded[c][hi]) begin
        if (k == span) return value_t'(1 << FracBits);
        // inputs whose scaled value falls in [k, k+1)
        lo_v = (k * (1 << FracBits) + span - 1) / span;
        hi_v = ((k + 1) * (1 << FracBits) + span - 1) / span - 1;
        return value_t'($urandom_range(hi_v, lo_v));
      end
    end
    return value_t'(0);
  endfunction

  // Entries 0, 1 and the last one always loaded (clamp paths); small tables
  // filled completely, large ones get a random run of neighbors.
  task automatic load_phase_tables();
    int span, start;
    span = sb.entry_count - 1;
    for (int c = 0; c < NumCh; c++) begin
      if (span < 64) begin
        for (int i = 0; i <= span; i++) write_lut(2'(c), AddrW'(i), rand_value());
      end else begin
        write_lut(2'(c), AddrW'(0), rand_value());
        write_lut(2'(c), AddrW'(1), rand_value());
        write_lut(2'(c), AddrW'(span), rand_value());
        start = $urandom_range(span - 16);
        for (int i = 0; i < 16; i++) write_lut(2'(c), AddrW'(start + i), rand_value());
      end
    end
  endtask

  // Mostly pixels, some table updates in flight, a few dropped writes.
  task automatic run_mixed_traffic(int count);
    int     done, sel;
    value_t r, g, b;
    done = 0;
    while (done < count) begin
      sel = $urandom_range(99);
      if (sel < 72) begin
        r = pick_channel_in(CH_RED);
        g = pick_channel_in(CH_GREEN);
        b = pick_channel_in(CH_BLUE);
        send_pixel(r, g, b, rand_value(), 1'($urandom()));
        done++;
      end else if (sel < 95) begin
        write_lut(2'($urandom_range(2)),
                  $urandom_range(1) ? AddrW'($urandom_range(sb.entry_count - 1))
                                    : AddrW'($urandom()),
                  rand_value());
        done++;
      end else begin
        write_lut(CH_NONE, AddrW'($urandom()), rand_value());
      end
    end
  endtask

  // Sink: random tready, or one long stall on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        m_axis_tready_i <= 1'b0;
        repeat (RxHoldCycles) @(posedge clk_i);
      end
      m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Output monitor
  always @(posedge clk_i) begin : out_monitor
    pixel_out_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.red       = value_t'(m_axis_tdata_o[19:0]);
      got.green     = value_t'(m_axis_tdata_o[39:20]);
      got.blue      = value_t'(m_axis_tdata_o[59:40]);
      got.alpha     = value_t'(m_axis_tdata_o[79:60]);
      got.frame_end = m_axis_tlast_o;
      sb.check_result(got);
    end
  end

  // Watchdog: any transfer on any channel resets the count.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("%0t ns: no transfer for %0d cycles", $time, WatchdogLimit);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    value_t corner_vals [NumCh][4];
    int     corner_idx [4];
    corner_vals = '{'{-20'sd524288, 20'sd524287, 20'sd0, 20'sd65536},
                    '{20'sd0, 20'sd65536, -20'sd65536, 20'sd524287},
                    '{20'sd65536, -20'sd65536, -20'sd524288, -20'sd1}};
    corner_idx  = '{0, 1, TableDepth - 2, TableDepth - 1};

    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = CMD_WRITE;
    s_axis_tlast_i  = 1'b0;
    m_axis_tready_i = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    tx_idle_pct     = 0;
    rx_idle_pct     = 0;
    rx_hold_req     = 1'b0;
    quiet_cycles    = 0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset entry count (4096): extreme table values at both ends
    // of each table, then a write on the unused channel that must be dropped.
    for (int c = 0; c < NumCh; c++) begin
      for (int i = 0; i < 4; i++) write_lut(2'(c), AddrW'(corner_idx[i]), corner_vals[c][i]);
    end
    write_lut(CH_NONE, AddrW'(TableDepth - 1), 20'sd123);

    // Clamped negative and large inputs, exact ends, max-swing interpolation
    // between min and max entries, alpha and tlast extremes.
    send_pixel(-20'sd524288, 20'sd524287, 20'sd0, -20'sd524288, 1'b0);
    send_pixel(20'sd16, 20'sd65535, 20'sd65536, 20'sd524287, 1'b1);
    send_pixel(20'sd1, -20'sd1, 20'sd15, 20'sd0, 1'b0);
    send_pixel(20'sd65536, 20'sd16, -20'sd524288, 20'sd12345, 1'b1);

    // Random phases; idle profile changes every three phases.
    for (int p = 0; p < NumPhases; p++) begin
      write_entry_count(PhaseCounts[p]);
      case (p / 3)
        0: begin
          tx_idle_pct = 14;
          rx_idle_pct = 73;
        end
        1: begin
          tx_idle_pct = 73;
          rx_idle_pct = 14;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      load_phase_tables();
      // sink stalls long while the source keeps pushing: backpressure to s_axis
      if (p == 6) rx_hold_req = 1'b1;
      run_mixed_traffic(PhaseItems);
    end

    drain_pipeline();
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rli_pkg.sv
rtl/rli_table_ram.sv
rtl/rli_scale.sv
rtl/rli_interp.sv
rtl/rgb_lut1d_linear_interp_core.sv
verif/tb_rgb_lut1d_linear_interp_core.sv
